FILE: rtl/core/utf8_codepoint_decoder_assert.svh
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset
`define UCD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define UCD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ucd_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; used by every module of the decoder.
`default_nettype none

package ucd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int REP_W       = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

    // One decoded request: a run of replacement characters, then an optional tail
    typedef struct packed {
        logic [REP_W-1:0] n_rep;
        logic             has_tail;
        logic [CP_W-1:0]  tail_cp;
        logic             tail_rep;
    } ucd_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/ucd_front.sv
// Front end: accepts input bytes, tracks the open sequence and classifies bytes
// into result requests. Depends on ucd_pkg and the assertion header.
`default_nettype none

`include "utf8_codepoint_decoder_assert.svh"

module ucd_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [ucd_pkg::BYTE_W-1:0] byte_in,
    output logic                            push_valid,
    input  wire logic                       push_ready,
    output ucd_pkg::ucd_cmd_t               push_cmd
);

    logic [ucd_pkg::CP_W-1:0]  partial_value_reg;
    logic [ucd_pkg::CP_W-1:0]  partial_value_next;
    logic [1:0]                bytes_needed_reg;
    logic [1:0]                bytes_needed_next;
    logic [1:0]                bytes_taken_reg;
    logic [1:0]                bytes_taken_next;
    logic                      is_cont;
    logic                      accept;
    ucd_pkg::ucd_cmd_t         cmd;

    // Take a byte whenever the queue has room
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign is_cont  = (byte_in[7:6] == 2'b10);

    // Classify the byte and work out the next sequence state
    always_comb
    begin
        partial_value_next = partial_value_reg;
        bytes_needed_next  = bytes_needed_reg;
        bytes_taken_next   = bytes_taken_reg;
        cmd                = '0;
        if ((bytes_needed_reg != 2'd0) && is_cont)
        begin
            partial_value_next = {partial_value_reg[ucd_pkg::CP_W-7:0], byte_in[5:0]};
            bytes_needed_next  = bytes_needed_reg - 2'd1;
            bytes_taken_next   = bytes_taken_reg + 2'd1;
            if (bytes_needed_reg == 2'd1)
            begin
                cmd.has_tail       = 1'b1;
                cmd.tail_cp        = partial_value_next;
                partial_value_next = '0;
                bytes_taken_next   = 2'd0;
            end
        end
        else
        begin
            // Flush a broken sequence: one replacement for the lead and each continuation
            if (bytes_needed_reg != 2'd0)
            begin
                cmd.n_rep = bytes_taken_reg + 2'd1;
            end
            partial_value_next = '0;
            bytes_needed_next  = 2'd0;
            bytes_taken_next   = 2'd0;
            // Decode the byte afresh
            if (byte_in == 8'h00)
            begin
                cmd.has_tail = 1'b0;
            end
            else if (byte_in inside {[8'h01:8'h7F]})
            begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = ucd_pkg::CP_W'(byte_in[6:0]);
            end
            else if (byte_in inside {[8'hC0:8'hDF]})
            begin
                partial_value_next = ucd_pkg::CP_W'(byte_in[4:0]);
                bytes_needed_next  = 2'd1;
            end
            else if (byte_in inside {[8'hE0:8'hEF]})
            begin
                partial_value_next = ucd_pkg::CP_W'(byte_in[3:0]);
                bytes_needed_next  = 2'd2;
            end
            else if (byte_in inside {[8'hF0:8'hF7]})
            begin
                partial_value_next = ucd_pkg::CP_W'(byte_in[2:0]);
                bytes_needed_next  = 2'd3;
            end
            else
            begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = ucd_pkg::CP_REPLACEMENT;
                cmd.tail_rep = 1'b1;
            end
        end
    end

    // Push only bytes that cause at least one result
    assign push_valid = in_valid && ((cmd.n_rep != 2'd0) || cmd.has_tail);
    assign push_cmd   = cmd;

    // Advance the sequence state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_value_reg <= '0;
            bytes_needed_reg  <= 2'd0;
            bytes_taken_reg   <= 2'd0;
        end
        else if (accept)
        begin
            partial_value_reg <= partial_value_next;
            bytes_needed_reg  <= bytes_needed_next;
            bytes_taken_reg   <= bytes_taken_next;
        end
    end

    `UCD_ASSERT_IMPLY(a_idle_no_taken, bytes_needed_reg == 2'd0, bytes_taken_reg == 2'd0,
        "continuation count left over with no open sequence")
    `UCD_ASSERT_ALWAYS(a_seq_len, ({1'b0, bytes_needed_reg} + {1'b0, bytes_taken_reg}) <= 3'd3,
        "open sequence longer than four bytes")
    `UCD_ASSERT_IMPLY(a_push_nonempty, push_valid, (push_cmd.n_rep != 2'd0) || push_cmd.has_tail,
        "request pushed with no result in it")

endmodule

`default_nettype wire

FILE: rtl/core/ucd_fifo.sv
// Short request queue between the front end and the result generator.
// Depends on ucd_pkg and the assertion header.
`default_nettype none

`include "utf8_codepoint_decoder_assert.svh"

module ucd_fifo #(
    parameter int DEPTH = ucd_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire ucd_pkg::ucd_cmd_t push_cmd,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output ucd_pkg::ucd_cmd_t      pop_cmd
);

    localparam int AW = $clog2(DEPTH);

    ucd_pkg::ucd_cmd_t mem_reg [DEPTH];
    logic [AW:0]       wr_ptr_reg;
    logic [AW:0]       rd_ptr_reg;
    logic [AW:0]       level;
    logic              full;
    logic              empty;

    // Pointers carry one extra wrap bit to tell full from empty
    assign empty      = (wr_ptr_reg == rd_ptr_reg);
    assign full       = (wr_ptr_reg[AW] != rd_ptr_reg[AW])
                     && (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign level      = wr_ptr_reg - rd_ptr_reg;
    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign pop_cmd    = mem_reg[rd_ptr_reg[AW-1:0]];

    // Advance the pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push_valid && push_ready)
            begin
                wr_ptr_reg <= wr_ptr_reg + (AW+1)'(1);
            end
            if (pop_valid && pop_ready)
            begin
                rd_ptr_reg <= rd_ptr_reg + (AW+1)'(1);
            end
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= push_cmd;
        end
    end

    `UCD_ASSERT_ALWAYS(a_level_bound, level <= (AW+1)'(DEPTH),
        "queue holds more requests than its depth")

endmodule

`default_nettype wire

FILE: rtl/core/ucd_back.sv
// Result generator: expands each queued request into code points behind an output register,
// one per cycle unless the receiver stalls. Depends on ucd_pkg and the assertion header.
`default_nettype none

`include "utf8_codepoint_decoder_assert.svh"

module ucd_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     pop_valid,
    output logic                          pop_ready,
    input  wire ucd_pkg::ucd_cmd_t        pop_cmd,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [ucd_pkg::CP_W-1:0]      code_point,
    output logic                          replaced,
    output logic                          last
);

    logic                         cmd_valid_reg;
    logic                         cmd_valid_next;
    logic [ucd_pkg::REP_W-1:0]    rep_left_reg;
    logic [ucd_pkg::REP_W-1:0]    rep_left_next;
    logic                         has_tail_reg;
    logic [ucd_pkg::CP_W-1:0]     tail_cp_reg;
    logic                         tail_rep_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [ucd_pkg::CP_W-1:0]     code_point_reg;
    logic                         replaced_reg;
    logic                         last_reg;
    logic                         slot_free;
    logic                         emit;
    logic                         emit_last;
    logic                         take;

    // Emit one result whenever the output register is free
    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = cmd_valid_reg && slot_free;
    assign emit_last = (rep_left_reg == '0)
                    || ((rep_left_reg == ucd_pkg::REP_W'(1)) && !has_tail_reg);
    assign pop_ready = !cmd_valid_reg || (emit && emit_last);
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        rep_left_next  = rep_left_reg;
        if (emit && (rep_left_reg != '0))
        begin
            rep_left_next = rep_left_reg - ucd_pkg::REP_W'(1);
        end
        if (emit && emit_last)
        begin
            cmd_valid_next = 1'b0;
        end
        if (take)
        begin
            cmd_valid_next = 1'b1;
            rep_left_next  = pop_cmd.n_rep;
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rep_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rep_left_reg  <= rep_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the request payload and the output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            has_tail_reg <= pop_cmd.has_tail;
            tail_cp_reg  <= pop_cmd.tail_cp;
            tail_rep_reg <= pop_cmd.tail_rep;
        end
        if (emit)
        begin
            if (rep_left_reg != '0)
            begin
                code_point_reg <= ucd_pkg::CP_REPLACEMENT;
                replaced_reg   <= 1'b1;
            end
            else
            begin
                code_point_reg <= tail_cp_reg;
                replaced_reg   <= tail_rep_reg;
            end
            last_reg <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;
    assign replaced   = replaced_reg;
    assign last       = last_reg;

    `UCD_ASSERT_IMPLY(a_cmd_has_work, cmd_valid_reg && (rep_left_reg == '0), has_tail_reg,
        "active request has no result left to give")

endmodule

`default_nettype wire

FILE: rtl/core/utf8_codepoint_decoder.sv
// UTF-8 code point decoder: front end, request queue and result generator.
// Depends on ucd_pkg, ucd_front, ucd_fifo and ucd_back.
//
// Usage:
//   Input channel: in_valid/in_ready carry one text byte (byte_in) per request.
//   Output channel: out_valid/out_ready carry one code point per request, with
//   replaced set on U+FFFD substitutes and last set on the final result of a byte.
//   A byte causes zero to four results; middle continuation bytes, and lead and
//   zero bytes with no open sequence, cause none.
//   The first result of a byte passes the request queue, then the output register.
//   Throughput: one byte per cycle while each byte gives at most one result and
//   the receiver does not stall; a byte giving several results holds the output
//   until all are given, the single output register being the limiting point.
//   A four-entry request queue separates the front end from the output, so bytes
//   keep flowing while a multi-result byte drains.
//   Reset clears the open sequence, empties the queue and drops out_valid.
//   When the receiver stalls the current result holds; in_ready falls once the
//   queue is full and rises as soon as one request leaves it.
`default_nettype none

module utf8_codepoint_decoder #(
    parameter int QUEUE_DEPTH = ucd_pkg::QUEUE_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [ucd_pkg::BYTE_W-1:0] byte_in,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [ucd_pkg::CP_W-1:0]        code_point,
    output logic                            replaced,
    output logic                            last
);

    logic              push_valid;
    logic              push_ready;
    ucd_pkg::ucd_cmd_t push_cmd;
    logic              pop_valid;
    logic              pop_ready;
    ucd_pkg::ucd_cmd_t pop_cmd;

    ucd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    ucd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    ucd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .replaced   (replaced),
        .last       (last)
    );

endmodule

`default_nettype wire

FILE: tb/sv/utf8_codepoint_decoder_tb.sv
// Self-checking testbench for the UTF-8 code point decoder: directed byte strings,
// then random text under four idling patterns, checked by an in-bench decoder model.
// Depends on ucd_pkg and utf8_codepoint_decoder.
`default_nettype none

module utf8_codepoint_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ucd_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int BYTES_PER_PASS = 88;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [CP_W-1:0] cp;
        logic            rep;
        logic            lst;
    } code_point_t;

    // Software decoder plus the queue of code points it still owes
    class codepoint_board;
        logic [CP_W-1:0] partial;
        logic [1:0]      need;
        logic [1:0]      taken;
        code_point_t     due_points[$];
        int unsigned     errors;
        int unsigned     checked;

        function new();
            partial = '0;
            need    = '0;
            taken   = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function void owe(logic [CP_W-1:0] cp, logic rep);
            code_point_t r;
            r.cp  = cp;
            r.rep = rep;
            r.lst = 1'b0;
            due_points.push_back(r);
        endfunction

        function void clear_seq();
            partial = '0;
            need    = '0;
            taken   = '0;
        endfunction

        // Decode a byte with no sequence open
        function void decode_lead(logic [BYTE_W-1:0] b);
            if (b == 8'h00)
            begin
                clear_seq();
            end
            else if (b[7] == 1'b0)
            begin
                owe(CP_W'(b), 1'b0);
            end
            else if (b[7:5] == 3'b110)
            begin
                partial = CP_W'(b[4:0]);
                need    = 2'd1;
                taken   = 2'd0;
            end
            else if (b[7:4] == 4'b1110)
            begin
                partial = CP_W'(b[3:0]);
                need    = 2'd2;
                taken   = 2'd0;
            end
            else if (b[7:3] == 5'b11110)
            begin
                partial = CP_W'(b[2:0]);
                need    = 2'd3;
                taken   = 2'd0;
            end
            else
            begin
                owe(CP_REPLACEMENT, 1'b1);
            end
        endfunction

        // Note an accepted byte and queue the code points it causes
        function void take_byte(logic [BYTE_W-1:0] b);
            int unsigned before_n;
            before_n = due_points.size();
            if (need != 2'd0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    partial = {partial[CP_W-7:0], b[5:0]};
                    need    = need - 2'd1;
                    taken   = taken + 2'd1;
                    if (need == 2'd0)
                    begin
                        owe(partial, 1'b0);
                        clear_seq();
                    end
                end
                else
                begin
                    // broken sequence: one substitute for the lead and each continuation
                    repeat (int'(taken) + 1) owe(CP_REPLACEMENT, 1'b1);
                    clear_seq();
                    decode_lead(b);
                end
            end
            else
            begin
                decode_lead(b);
            end
            if (due_points.size() > before_n)
                due_points[due_points.size() - 1].lst = 1'b1;
        endfunction

        // Compare one accepted result with the oldest code point owed
        function void check_point(logic [CP_W-1:0] cp, logic rep, logic lst);
            code_point_t want;
            checked++;
            if (due_points.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: code_point=%h replaced=%b last=%b",
                             cp, rep, lst);
                return;
            end
            want = due_points.pop_front();
            if (cp !== want.cp || rep !== want.rep || lst !== want.lst)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result %0d: expected cp=%h rep=%b last=%b, got cp=%h rep=%b last=%b",
                             checked, want.cp, want.rep, want.lst, cp, rep, lst);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    byte_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [CP_W-1:0]      code_point;
    logic                 replaced;
    logic                 last;

    codepoint_board       board;
    logic [BYTE_W-1:0]    text_bytes[$];
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;
    int unsigned          bytes_sent;
    int unsigned          quiet_cycles;

    utf8_codepoint_decoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .replaced   (replaced),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Stall the receiver at random on the falling edge
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_point(code_point, replaced, last);
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
                $display("utf8_codepoint_decoder: mismatch");
                $finish;
            end
        end
    end

    // Offer one byte, idling first at random, and hold it until accepted
    task automatic send_byte(logic [BYTE_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        board.take_byte(b);
        bytes_sent++;
    endtask

    // Queue random text: mostly well-formed sequences, some broken ones and noise
    task automatic queue_random_text(int unsigned n_bytes);
        int unsigned       kind;
        int unsigned       n_cont;
        int unsigned       k;
        logic [BYTE_W-1:0] b;
        while (text_bytes.size() < n_bytes)
        begin
            kind   = $urandom_range(0, 99);
            n_cont = $urandom_range(1, 3);
            if (kind < 25)
            begin
                text_bytes.push_back(BYTE_W'($urandom_range(1, 127)));
            end
            else if (kind < 80 && kind >= 35 || kind >= 80 && kind < 92)
            begin
                case (n_cont)
                    1: text_bytes.push_back({3'b110, 5'($urandom)});
                    2: text_bytes.push_back({4'b1110, 4'($urandom)});
                    default: text_bytes.push_back({5'b11110, 3'($urandom)});
                endcase
                // complete the sequence, or cut it short with a non-continuation
                k = (kind < 80) ? n_cont : $urandom_range(0, n_cont - 1);
                repeat (k) text_bytes.push_back({2'b10, 6'($urandom)});
                if (kind >= 80)
                begin
                    b = BYTE_W'($urandom);
                    while (b[7:6] == 2'b10)
                        b = BYTE_W'($urandom);
                    text_bytes.push_back(b);
                end
            end
            else if (kind < 35)
            begin
                if ($urandom_range(0, 1) == 0)
                    text_bytes.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
                else
                    text_bytes.push_back(BYTE_W'($urandom_range(8'hF8, 8'hFF)));
            end
            else if (kind < 96)
            begin
                text_bytes.push_back(8'h00);
            end
            else
            begin
                text_bytes.push_back(BYTE_W'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        byte_in        = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        quiet_cycles   = 0;
        board          = new();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed text: end marker at idle, ASCII bytes, a stray continuation, an invalid byte,
        // each sequence length, a proper U+FFFD, the largest code point, broken and flushed sequences
        text_bytes = '{8'h00, 8'h41, 8'h7F, 8'h80, 8'hFF,
                       8'hC2, 8'hA9,
                       8'hF0, 8'h9F, 8'h98, 8'h80,
                       8'hEF, 8'hBF, 8'hBD,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF,
                       8'hE2, 8'h82, 8'h41,
                       8'hF0, 8'h9F, 8'h98, 8'hFE,
                       8'hC3, 8'h00};

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            queue_random_text(text_bytes.size() + BYTES_PER_PASS);
            while (text_bytes.size() != 0)
                send_byte(text_bytes.pop_front());
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain what is owed, then watch for stray results
        while (board.due_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes over four idling patterns, checked %0d code points",
                 bytes_sent, board.checked);
        $display("%0d mismatches, %0d code points still owed",
                 board.errors, board.due_points.size());
        if (board.errors == 0 && board.due_points.size() == 0)
            $display("utf8_codepoint_decoder: match");
        else
            $display("utf8_codepoint_decoder: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
